// File: sv/sorted_set_insert_select_core_macros.svh
// assertion macros for the sorted set core
// expects clk and arst_n in the scope where a macro is used
`ifndef SORTED_SET_INSERT_SELECT_CORE_MACROS_SVH
`define SORTED_SET_INSERT_SELECT_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define SSIS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define SSIS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/ssis_pkg.sv
// shared types and codes of the sorted set insert / select core
// no dependencies
package ssis_pkg;

	localparam int DEPTH_DEF = 64;

	// func codes
	localparam logic [1:0] FUNC_INSERT   = 2'd0;
	localparam logic [1:0] FUNC_SEL_HALF = 2'd1;
	localparam logic [1:0] FUNC_SEL_POS  = 2'd2;

	// status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_DUP   = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;
	localparam logic [1:0] STAT_EMPTY = 2'd3;

	localparam int HELD_W = 7;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [31:0] value;
		logic [7:0]         count_arg;
	} item_t;

	typedef struct packed {
		logic signed [31:0]  selected;
		logic [1:0]          status;
		logic [HELD_W-1:0]   held;
	} result_t;

endpackage

// File: sv/sorted_set_insert_select_core.sv
// sorted set of distinct signed 32-bit values with insert and positional select
// depends on ssis_pkg and sorted_set_insert_select_core_macros.svh
//
//  channel  | valid         | stall         | payload
//  ---------+---------------+---------------+-------------------------------
//  item     | item_valid    | item_stall    | item   (func, value, count_arg)
//  result   | result_valid  | result_stall  | result (selected, status, held)
//
// one item at a time; the values live in one DEPTH x 32 memory (registered read)
// insert: scan up to the insert point, top-down shift of the entries from there up,
//   write, finish
// select: accept with read, capture, finish; other codes and a select on an empty set: accept, finish
// reset clears the fill count, state and valid flags but not the memory; memory contents need no clearing pass
// a stalled result beat blocks only the next finish, never the next item
`include "sorted_set_insert_select_core_macros.svh"

module sorted_set_insert_select_core #(
	parameter int DEPTH = ssis_pkg::DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  ssis_pkg::item_t  item,
	output logic             result_valid,
	input  logic             result_stall,
	output ssis_pkg::result_t result
);
	import ssis_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > 8) ? CW : 8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_PUT,
		ST_SEL,
		ST_FIN
	} state_t;

	state_t state_q;

	// value memory, one write and one registered read port
	logic signed [31:0] mem [DEPTH];
	logic signed [31:0] rd_data_s1;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic signed [31:0] wr_data;

	// control and item registers
	logic [CW-1:0]      count_q;
	logic signed [31:0] val_q;
	logic [CW-1:0]      issue_q;   // next scan address
	logic [CW-1:0]      pos_q;     // insert position
	logic [CW-1:0]      left_q;    // shift reads still to issue
	logic [AW-1:0]      src_q;     // next shift source address
	logic               rdv_s1;    // a read is in flight
	logic [AW-1:0]      rdidx_s1;  // its address
	logic signed [31:0] res_sel_q;
	logic [1:0]         res_stat_q;
	logic               out_valid_q;
	result_t            out_q;

	logic item_acc;
	logic out_free;

	// select position
	logic [7:0]    half;
	logic [7:0]    sel_raw;
	logic [CW-1:0] last_idx;
	logic [AW-1:0] sel_addr;

	// scan results
	logic          scan_dup;
	logic          scan_stop;
	logic [CW-1:0] scan_pos;

	assign item_stall   = (state_q != ST_IDLE);
	assign item_acc     = item_valid && !item_stall;
	assign out_free     = !out_valid_q || !result_stall;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	// half select: max(count_arg/2 - 1, 0); position select: count_arg; clamp to last
	always_comb begin
		half     = {1'b0, item.count_arg[7:1]};
		sel_raw  = (item.func == FUNC_SEL_HALF) ? ((half != 8'd0) ? half - 8'd1 : 8'd0)
			: item.count_arg;
		last_idx = count_q - CW'(1);
		if (PW'(sel_raw) > PW'(last_idx)) begin
			sel_addr = AW'(last_idx);
		end else begin
			sel_addr = AW'(sel_raw);
		end
	end

	// compare stage of the upward scan
	always_comb begin
		scan_dup  = 1'b0;
		scan_stop = 1'b0;
		scan_pos  = count_q;
		if (rdv_s1) begin
			if (rd_data_s1 == val_q) begin
				scan_dup = 1'b1;
			end else if (rd_data_s1 > val_q) begin
				scan_stop = 1'b1;
				scan_pos  = CW'(rdidx_s1);
			end
		end else if (issue_q == count_q) begin
			// every stored value is smaller: append
			scan_stop = 1'b1;
		end
	end

	// memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = val_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_acc && (item.func == FUNC_SEL_HALF || item.func == FUNC_SEL_POS)
						&& count_q != '0) begin
					rd_en   = 1'b1;
					rd_addr = sel_addr;
				end
			end
			ST_SCAN: begin
				if (issue_q < count_q) begin
					rd_en   = 1'b1;
					rd_addr = issue_q[AW-1:0];
				end
			end
			ST_SHIFT: begin
				if (left_q != '0) begin
					rd_en   = 1'b1;
					rd_addr = src_q;
				end
				// entry moves up by one
				if (rdv_s1) begin
					wr_en   = 1'b1;
					wr_addr = rdidx_s1 + AW'(1);
					wr_data = rd_data_s1;
				end
			end
			ST_PUT: begin
				wr_en   = 1'b1;
				wr_addr = pos_q[AW-1:0];
				wr_data = val_q;
			end
			ST_SEL, ST_FIN: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			rdv_s1      <= 1'b0;
			issue_q     <= '0;
			left_q      <= '0;
		end else begin
			// the finish state reloads the output register itself
			if (out_valid_q && !result_stall && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						val_q     <= item.value;
						res_sel_q <= '0;
						priority if (item.func == FUNC_INSERT) begin
							res_stat_q <= STAT_OK;
							if (count_q == '0) begin
								pos_q   <= '0;
								state_q <= ST_PUT;
							end else begin
								issue_q <= '0;
								rdv_s1  <= 1'b0;
								state_q <= ST_SCAN;
							end
						end else if (item.func == FUNC_SEL_HALF
								|| item.func == FUNC_SEL_POS) begin
							if (count_q == '0) begin
								res_stat_q <= STAT_EMPTY;
								state_q    <= ST_FIN;
							end else begin
								res_stat_q <= STAT_OK;
								state_q    <= ST_SEL;
							end
						end else begin
							// unused code: no change, plain ok
							res_stat_q <= STAT_OK;
							state_q    <= ST_FIN;
						end
					end
				end
				ST_SEL: begin
					res_sel_q <= rd_data_s1;
					state_q   <= ST_FIN;
				end
				ST_SCAN: begin
					// nothing stays in flight once the scan ends
					rdv_s1   <= rd_en && !scan_dup && !scan_stop;
					rdidx_s1 <= rd_addr;
					if (rd_en) begin
						issue_q <= issue_q + CW'(1);
					end
					priority if (scan_dup) begin
						res_stat_q <= STAT_DUP;
						state_q    <= ST_FIN;
					end else if (scan_stop) begin
						pos_q  <= scan_pos;
						if (count_q >= CW'(DEPTH)) begin
							res_stat_q <= STAT_FULL;
							state_q    <= ST_FIN;
						end else if (scan_pos == count_q) begin
							state_q <= ST_PUT;
						end else begin
							left_q  <= count_q - scan_pos;
							src_q   <= AW'(count_q - CW'(1));
							state_q <= ST_SHIFT;
						end
					end
				end
				ST_SHIFT: begin
					rdv_s1   <= rd_en;
					rdidx_s1 <= rd_addr;
					if (rd_en) begin
						left_q <= left_q - CW'(1);
						src_q  <= src_q - AW'(1);
					end
					if (left_q == '0 && !rdv_s1) begin
						state_q <= ST_PUT;
					end
				end
				ST_PUT: begin
					count_q <= count_q + CW'(1);
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						out_q.selected <= res_sel_q;
						out_q.status   <= res_stat_q;
						out_q.held     <= HELD_W'(count_q);
						out_valid_q    <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// checks
	`SSIS_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(DEPTH), "fill count past depth")
	`SSIS_ASSERT_NOW(a_wr_state, wr_en, state_q == ST_SHIFT || state_q == ST_PUT, "stray write")
	`SSIS_ASSERT_NOW(a_no_collide, wr_en && rd_en, wr_addr != rd_addr, "read/write same entry")
	`SSIS_ASSERT_NEXT(a_acc_busy, item_acc, state_q != ST_IDLE, "accepted item lost")

endmodule

// File: tb/sv/testbench.sv
// self-checking testbench for sorted_set_insert_select_core
// depends on ssis_pkg and the core; a scoreboard class keeps its own sorted copy of the set
// and predicts every result beat, plain tasks drive the item channel

module testbench;
	import ssis_pkg::*;

	// func code 3 has no meaning in the package, the core must answer it as a no-op
	localparam logic [1:0] FUNC_NONE = 2'd3;

	localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

	localparam int RANDOM_ITEMS = 1200;
	// give the tail a lot more time than the slowest insert takes
	localparam int TAIL_CYCLES  = 2 * DEPTH_DEF + 20;
	// ~1220 items, each at the slowest insert, plus stalls stay far below this
	localparam int CYCLE_LIMIT  = 1_000_000;

	// holds the expected view of the set and the results still owed by the core
	class sorted_set_scoreboard;
		logic signed [31:0] vals [DEPTH_DEF];
		int unsigned        fill;
		result_t            owed_results [$];
		int unsigned        mismatches;
		int unsigned        checked;
		int unsigned        status_seen [4];

		function new();
			fill = 0;
			mismatches = 0;
			checked = 0;
			foreach (status_seen[i])
				status_seen[i] = 0;
		endfunction

		// apply one accepted item beat to the set copy and queue the answer it must produce
		function void note_item(item_t it);
			result_t            r;
			logic signed [31:0] v;
			int unsigned        pos;
			int unsigned        half;
			r = '0;
			v = it.value;
			pos = 0;
			case (it.func)
			FUNC_INSERT: begin
				// first slot whose value is not below the new one
				while (pos < fill && vals[pos] < v)
					pos++;
				if (pos < fill && vals[pos] == v) begin
					r.status = STAT_DUP;
				end else if (fill >= DEPTH_DEF) begin
					r.status = STAT_FULL;
				end else begin
					for (int i = fill; i > pos; i--)
						vals[i] = vals[i-1];
					vals[pos] = v;
					fill++;
				end
			end
			FUNC_SEL_HALF, FUNC_SEL_POS: begin
				if (fill == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					if (it.func == FUNC_SEL_HALF) begin
						half = 32'(it.count_arg) / 2;
						pos = (half >= 1) ? half - 1 : 0;
					end else begin
						pos = 32'(it.count_arg);
					end
					if (pos > fill - 1)
						pos = fill - 1;
					r.selected = vals[pos];
				end
			end
			default: ;
			endcase
			r.held = fill[HELD_W-1:0];
			owed_results.push_back(r);
		endfunction

		// compare one accepted result beat against the oldest owed answer
		function void check_result(result_t got);
			result_t want;
			if (owed_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: selected %0d status %0d held %0d",
						got.selected, got.status, got.held);
				return;
			end
			want = owed_results.pop_front();
			checked++;
			status_seen[got.status]++;
			if (got.selected !== want.selected || got.status !== want.status ||
				got.held !== want.held) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d exp/got: selected %0d/%0d status %0d/%0d held %0d/%0d",
						checked, want.selected, got.selected, want.status, got.status,
						want.held, got.held);
			end
		endfunction
	endclass

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	sorted_set_scoreboard sb = new();

	// no idling on either side while this is set
	bit          calm = 1'b0;
	int unsigned cycles = 0;
	int unsigned items_sent = 0;

	always #5 clk = ~clk;

	sorted_set_insert_select_core #(
		.DEPTH(DEPTH_DEF)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	// both channels are observed at the rising edge, before any flop of the core updates
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall)
				sb.note_item(item);
			if (result_valid && !result_stall)
				sb.check_result(result);
		end
	end

	// receiver side: random stall about 15 percent of the time, none in the calm stretch
	always @(negedge clk) begin
		result_stall <= !calm && ($urandom_range(99) < 15);
	end

	// hard stop in case the core hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed", cycles,
				sb.owed_results.size());
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic item_t make_item(input logic [1:0] f, input logic signed [31:0] v,
		input logic [7:0] c);
		item_t it;
		it.func = f;
		it.value = v;
		it.count_arg = c;
		return it;
	endfunction

	// present one beat at the falling edge and hold it until the core takes it;
	// returns at the falling edge after acceptance with valid still high
	task automatic send_item(input item_t it);
		while (!calm && $urandom_range(99) < 15) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (item_stall);
		@(negedge clk);
		items_sent++;
	endtask

	// stop sending until every owed result has come back
	task automatic settle_all();
		item_valid <= 1'b0;
		@(negedge clk);
		while (sb.owed_results.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		item_t       it;
		int unsigned roll;
		int unsigned k;

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty table first, then extremes, duplicates and clamped selects
		send_item(make_item(FUNC_SEL_HALF, 32'sd7, 8'd0));
		send_item(make_item(FUNC_SEL_POS, -32'sd7, 8'd255));
		send_item(make_item(FUNC_NONE, -32'sd1, 8'd255));
		send_item(make_item(FUNC_INSERT, 32'sd0, 8'd0));
		send_item(make_item(FUNC_INSERT, 32'sd0, 8'd255));
		send_item(make_item(FUNC_INSERT, VAL_MAX, 8'd0));
		send_item(make_item(FUNC_INSERT, VAL_MIN, 8'd0));
		send_item(make_item(FUNC_INSERT, -32'sd1, 8'd0));
		send_item(make_item(FUNC_INSERT, 32'sd1, 8'd0));
		send_item(make_item(FUNC_INSERT, VAL_MIN, 8'd0));
		send_item(make_item(FUNC_INSERT, VAL_MAX, 8'd0));
		send_item(make_item(FUNC_SEL_HALF, 32'sd0, 8'd0));
		send_item(make_item(FUNC_SEL_HALF, 32'sd0, 8'd1));
		send_item(make_item(FUNC_SEL_HALF, 32'sd0, 8'd2));
		send_item(make_item(FUNC_SEL_HALF, 32'sd0, 8'd5));
		send_item(make_item(FUNC_SEL_HALF, VAL_MAX, 8'd255));
		send_item(make_item(FUNC_SEL_POS, 32'sd0, 8'd0));
		send_item(make_item(FUNC_SEL_POS, 32'sd0, 8'd4));
		send_item(make_item(FUNC_SEL_POS, 32'sd0, 8'd5));
		send_item(make_item(FUNC_SEL_POS, VAL_MIN, 8'd255));
		send_item(make_item(FUNC_NONE, 32'sh5555_AAAA, 8'hAA));
		send_item(make_item(FUNC_INSERT, 32'sh7FFF_FFFE, 8'h55));
		send_item(make_item(FUNC_SEL_POS, 32'sd0, 8'd5));
		settle_all();

		// random: inserts fill the table within the first couple hundred beats,
		// the rest hammers duplicates, full-table inserts and selects on every slot
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			calm = (n >= 500 && n < 800);
			if (n == 600 || n == 1000)
				settle_all();
			roll = $urandom_range(99);
			it.value = $urandom;
			it.count_arg = 8'($urandom_range(255));
			if (roll < 45) begin
				it.func = FUNC_INSERT;
				case ($urandom_range(9))
				0, 1: begin
					// repeat a stored value
					if (sb.fill != 0)
						it.value = sb.vals[$urandom_range(sb.fill - 1)];
				end
				2: begin
					case ($urandom_range(3))
					0: it.value = VAL_MIN;
					1: it.value = VAL_MAX;
					2: it.value = 32'sd0;
					default: it.value = -32'sd1;
					endcase
				end
				3: begin
					// neighbor of a stored value, lands right next to it
					if (sb.fill != 0) begin
						k = $urandom_range(sb.fill - 1);
						it.value = $urandom_range(1) ? sb.vals[k] + 32'sd1 : sb.vals[k] - 32'sd1;
					end
				end
				default: ;
				endcase
			end else if (roll < 97) begin
				it.func = (roll < 71) ? FUNC_SEL_HALF : FUNC_SEL_POS;
				// half the selects stay near the filled range so most slots get picked
				if ($urandom_range(1))
					it.count_arg = 8'($urandom_range(2 * sb.fill + 1));
			end else begin
				it.func = FUNC_NONE;
			end
			send_item(it);
		end

		item_valid <= 1'b0;
		while (sb.owed_results.size() != 0)
			@(negedge clk);
		// catch any stray beat the core might still emit
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("sent %0d items, checked %0d results: %0d ok, %0d dup, %0d full, %0d empty",
			items_sent, sb.checked, sb.status_seen[STAT_OK], sb.status_seen[STAT_DUP],
			sb.status_seen[STAT_FULL], sb.status_seen[STAT_EMPTY]);
		$display("set ended with %0d of %0d values stored, %0d mismatches in %0d cycles",
			sb.fill, DEPTH_DEF, sb.mismatches, cycles);
		if (sb.mismatches == 0 && sb.owed_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: sorted_set_insert_select_core.f
+incdir+sv
sv/ssis_pkg.sv
sv/sorted_set_insert_select_core.sv
tb/sv/testbench.sv
